>>> rtl/xpd_pkg.sv
// Shared types and constants for the x86 prefix decoder.
// Holds transfer structs, prefix encodings, status codes and the prefix lookup.
// No dependencies.
package xpd_pkg;

    // Input transfer: one code byte or an end-of-code marker
    typedef struct packed {
        logic [7:0] code_byte;
        logic       code_ended;
    } in_item_t;

    // Output transfer: one decoded prefix run
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] lock_rep_prefix;
        logic [2:0] segment_prefix;
        logic       operand_size_override;
        logic       address_size_override;
        logic       rex_present;
        logic       rex_w;
        logic       rex_r;
        logic       rex_x;
        logic       rex_b;
        logic [3:0] bytes_consumed;
    } out_item_t;

    // Prefix slots collected so far for the current instruction
    typedef struct packed {
        logic [1:0] group1;
        logic [2:0] group2;
        logic       group3;
        logic       group4;
        logic [3:0] count;
    } slots_t;

    // Result of one decode step
    typedef struct packed {
        logic      emit;
        out_item_t result;
        slots_t    slots;
    } step_t;

    typedef enum logic [2:0] {
        GRP_NONE,
        GRP_LOCK_REP,
        GRP_SEGMENT,
        GRP_OPSIZE,
        GRP_ADDRSIZE
    } grp_t;

    typedef struct packed {
        grp_t       grp;
        logic [2:0] code;
    } prefix_t;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [1:0] STATUS_ENDED    = 2'd2;

    // Prefix byte encodings
    localparam logic [7:0] PFX_LOCK  = 8'hf0;
    localparam logic [7:0] PFX_REPNZ = 8'hf2;
    localparam logic [7:0] PFX_REP   = 8'hf3;
    localparam logic [7:0] PFX_CS    = 8'h2e;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3e;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;

    // REX bytes are 0x40..0x4F
    localparam logic [7:0] REX_MASK  = 8'hf0;
    localparam logic [7:0] REX_MATCH = 8'h40;

    // Slot codes
    localparam logic [1:0] G1_LOCK  = 2'd1;
    localparam logic [1:0] G1_REPNZ = 2'd2;
    localparam logic [1:0] G1_REP   = 2'd3;
    localparam logic [2:0] G2_CS    = 3'd1;
    localparam logic [2:0] G2_SS    = 3'd2;
    localparam logic [2:0] G2_DS    = 3'd3;
    localparam logic [2:0] G2_ES    = 3'd4;
    localparam logic [2:0] G2_FS    = 3'd5;
    localparam logic [2:0] G2_GS    = 3'd6;

    // Configuration register map
    localparam int unsigned    PADDR_W       = 3;
    localparam logic [0:0]     REG_MODE_64BIT = 1'b0;

    // Map a byte to its legacy prefix group and slot code
    function automatic prefix_t decode_prefix(input logic [7:0] b);
        prefix_t p;
        p.grp  = GRP_NONE;
        p.code = 3'd0;
        case (b)
            PFX_LOCK:  begin p.grp = GRP_LOCK_REP; p.code = {1'b0, G1_LOCK};  end
            PFX_REPNZ: begin p.grp = GRP_LOCK_REP; p.code = {1'b0, G1_REPNZ}; end
            PFX_REP:   begin p.grp = GRP_LOCK_REP; p.code = {1'b0, G1_REP};   end
            PFX_CS:    begin p.grp = GRP_SEGMENT;  p.code = G2_CS; end
            PFX_SS:    begin p.grp = GRP_SEGMENT;  p.code = G2_SS; end
            PFX_DS:    begin p.grp = GRP_SEGMENT;  p.code = G2_DS; end
            PFX_ES:    begin p.grp = GRP_SEGMENT;  p.code = G2_ES; end
            PFX_FS:    begin p.grp = GRP_SEGMENT;  p.code = G2_FS; end
            PFX_GS:    begin p.grp = GRP_SEGMENT;  p.code = G2_GS; end
            PFX_OPSZ:  begin p.grp = GRP_OPSIZE;   p.code = 3'd1;  end
            PFX_ADSZ:  begin p.grp = GRP_ADDRSIZE; p.code = 3'd1;  end
            default:   begin p.grp = GRP_NONE;     p.code = 3'd0;  end
        endcase
        return p;
    endfunction

endpackage

>>> rtl/xpd_step.sv
// One decode step: current prefix slots plus one input byte give the next
// slots and, when the prefix run ends, a result. Depends on xpd_pkg.
module xpd_step #(
    parameter logic [3:0] CNT_CAP = 4'd15
) (
    input  xpd_pkg::slots_t   slots,
    input  xpd_pkg::in_item_t item,
    input  logic              mode_64bit,
    output xpd_pkg::step_t    step
);
    import xpd_pkg::*;

    prefix_t    pfx;
    logic [3:0] count_bumped;
    logic       is_rex;
    out_item_t  base;

    assign pfx          = decode_prefix(item.code_byte);
    assign count_bumped = (slots.count < CNT_CAP) ? slots.count + 4'd1 : slots.count;
    assign is_rex       = mode_64bit && ((item.code_byte & REX_MASK) == REX_MATCH);

    // Result built from the slots as they stand, no REX
    always_comb
    begin
        base.status                = STATUS_OK;
        base.lock_rep_prefix       = slots.group1;
        base.segment_prefix        = slots.group2;
        base.operand_size_override = slots.group3;
        base.address_size_override = slots.group4;
        base.rex_present           = 1'b0;
        base.rex_w                 = 1'b0;
        base.rex_r                 = 1'b0;
        base.rex_x                 = 1'b0;
        base.rex_b                 = 1'b0;
        base.bytes_consumed        = slots.count;
    end

    // Step decision
    always_comb
    begin
        step.emit   = 1'b0;
        step.result = base;
        step.slots  = slots;
        if (item.code_ended)
        begin
            step.emit          = 1'b1;
            step.result.status = mode_64bit ? STATUS_ENDED : STATUS_OK;
        end
        else
        begin
            case (pfx.grp)
                GRP_LOCK_REP:
                begin
                    if (slots.group1 != 2'd0 && slots.group1 != pfx.code[1:0])
                    begin
                        step.emit          = 1'b1;
                        step.result.status = STATUS_CONFLICT;
                    end
                    else
                    begin
                        step.slots.group1 = pfx.code[1:0];
                        step.slots.count  = count_bumped;
                    end
                end
                GRP_SEGMENT:
                begin
                    if (slots.group2 != 3'd0 && slots.group2 != pfx.code)
                    begin
                        step.emit          = 1'b1;
                        step.result.status = STATUS_CONFLICT;
                    end
                    else
                    begin
                        step.slots.group2 = pfx.code;
                        step.slots.count  = count_bumped;
                    end
                end
                GRP_OPSIZE:
                begin
                    step.slots.group3 = 1'b1;
                    step.slots.count  = count_bumped;
                end
                GRP_ADDRSIZE:
                begin
                    step.slots.group4 = 1'b1;
                    step.slots.count  = count_bumped;
                end
                default:
                begin
                    step.emit = 1'b1;
                    if (is_rex)
                    begin
                        step.result.rex_present    = 1'b1;
                        step.result.rex_w          = item.code_byte[3];
                        step.result.rex_r          = item.code_byte[2];
                        step.result.rex_x          = item.code_byte[1];
                        step.result.rex_b          = item.code_byte[0];
                        step.result.bytes_consumed = count_bumped;
                    end
                end
            endcase
        end
        // Every result ends the instruction
        if (step.emit)
        begin
            step.slots = '0;
        end
    end

endmodule

>>> rtl/x86_prefix_decoder.sv
// x86 legacy and REX prefix decoder. Takes one code byte per transfer and
// collects legacy prefixes (lock/rep, segment, operand size, address size)
// until the first non-prefix byte, a REX byte in 64-bit mode, a conflict
// between two different prefixes of one group, or end of code; then it
// delivers one result and clears its slots. Sustained rate is one byte per
// clock while no result waits on a full output register: each byte is
// registered at the input, decoded against the prefix slots
// combinationally, and a result lands in the output register. The slot
// update loop is a combinational decision on the slot register. Bytes that
// do not end a run produce no transfer on the output. mode_64bit is written
// over the APB port at address 0 and should only change while the decoder
// is idle. Depends on xpd_pkg and xpd_step.
module x86_prefix_decoder #(
    parameter int unsigned COUNT_LIMIT = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // byte stream
    input  logic                          in_valid,
    output logic                          in_ready,
    input  xpd_pkg::in_item_t             in_data,
    // results
    output logic                          out_valid,
    input  logic                          out_ready,
    output xpd_pkg::out_item_t            out_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [xpd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import xpd_pkg::*;

    localparam logic [3:0] CNT_CAP = (COUNT_LIMIT < 15) ? 4'(COUNT_LIMIT) : 4'd15;

    logic      mode_64bit_reg;
    logic      mode_64bit_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;
    in_item_t  in_item_next;
    slots_t    slots_reg;
    slots_t    slots_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    step_t     step;
    logic      advance;
    logic      cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_MODE_64BIT) ? {31'd0, mode_64bit_reg} : 32'd0;

    always_comb
    begin
        mode_64bit_next = mode_64bit_reg;
        if (cfg_write && paddr[PADDR_W-1:2] == REG_MODE_64BIT)
        begin
            mode_64bit_next = pwdata[0];
        end
    end

    // Decode against current slots
    xpd_step #(
        .CNT_CAP (CNT_CAP)
    ) u_step (
        .slots      (slots_reg),
        .item       (in_item_reg),
        .mode_64bit (mode_64bit_reg),
        .step       (step)
    );

    // Held byte moves on when it makes no result or the output register frees up
    assign advance  = in_valid_reg && (!step.emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_item_next  = in_data;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Slot state and output register
    always_comb
    begin
        slots_next     = slots_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (advance)
        begin
            slots_next = step.slots;
        end
        if (advance && step.emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = step.result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_64bit_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            slots_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_64bit_reg <= mode_64bit_next;
            in_valid_reg   <= in_valid_next;
            slots_reg      <= slots_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    // A run that ends clears every slot
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step.emit |=> slots_reg == '0)
        else $error("prefix slots not cleared after result");

    // A byte absorbed as prefix always leaves a nonzero count
    a_count_after_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !step.emit |=> slots_reg.count != 4'd0)
        else $error("prefix count zero after prefix byte");

    // Count never exceeds its cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg.count <= CNT_CAP)
        else $error("prefix count above cap");

    // Error results never carry REX
    a_error_no_rex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status != STATUS_OK |-> !out_item_reg.rex_present)
        else $error("REX reported with error status");
`endif

endmodule
